[src/md5_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 package
// Shared types, initial chaining values and the per-round constant tables.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // Four working or chaining words of the hash.
    typedef struct packed {
        logic [31:0] d;
        logic [31:0] c;
        logic [31:0] b;
        logic [31:0] a;
    } md5_state_t;

    // Additive constant of each round (integer part of |sin(i+1)| * 2^32).
    function automatic logic [31:0] md5_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Rotate amount, chosen by the round group and the low two round bits.
    function automatic logic [4:0] md5_shift(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;
            4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;
            4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // Message word used by each round; all arithmetic wraps at 16.
    function automatic logic [3:0] md5_index(input logic [5:0] r);
        logic [3:0] q;
        logic [3:0] g;
        q = r[3:0];
        case (r[5:4])
            2'd0:    g = q;
            2'd1:    g = q * 4'd5 + 4'd1;
            2'd2:    g = q * 4'd3 + 4'd5;
            2'd3:    g = q * 4'd7;
            default: g = q;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

[src/md5_round.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 round
// One compression round: boolean function, four-term add, rotate and
// the word shuffle that follows.
// ----------------------------------------------------------------------------
module md5_round
    import md5_pkg::*;
(
    input  wire md5_state_t  cur_state,
    input  wire logic [31:0] msg_word,
    input  wire logic [5:0]  round_idx,
    output md5_state_t       next_state
);

    logic [31:0] f_val;
    logic [31:0] sum;
    logic [63:0] rot_dbl;
    logic [4:0]  rot_amt;

    always_comb begin
        case (round_idx[5:4])
            2'd0:    f_val = (cur_state.b & cur_state.c) | (~cur_state.b & cur_state.d);
            2'd1:    f_val = (cur_state.b & cur_state.d) | (cur_state.c & ~cur_state.d);
            2'd2:    f_val = cur_state.b ^ cur_state.c ^ cur_state.d;
            2'd3:    f_val = cur_state.c ^ (cur_state.b | ~cur_state.d);
            default: f_val = 32'h0;
        endcase
    end

    assign rot_amt = md5_shift(round_idx);
    assign sum     = cur_state.a + f_val + md5_k(round_idx) + msg_word;
    // The upper half of the doubled word shifted left is the left rotation.
    assign rot_dbl = {sum, sum} << rot_amt;

    always_comb begin
        next_state.a = cur_state.d;
        next_state.d = cur_state.c;
        next_state.c = cur_state.b;
        next_state.b = cur_state.b + rot_dbl[63:32];
    end

endmodule
`default_nettype wire

[src/md5_message_digest.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 message digest
// Hashes a byte stream with standard MD5 and returns the 128-bit digest.
// ----------------------------------------------------------------------------
// The slave channel carries one message byte per transaction in s_tdata.
// s_tuser says whether the byte belongs to the message, and s_tlast ends the
// message. A transaction with s_tuser low and s_tlast high asks for the digest
// of the bytes sent so far (the empty message if none). A transaction with
// both low is ignored.
// Bytes are taken one per cycle while s_tready is high. Every 64th byte starts
// a compression of the block buffer while s_tready is low: a load state to
// prime the memory read, the 64 rounds and a fold of the result into the
// chaining value.
// After s_tlast the block writes the padding and length one byte per cycle
// between compressions (9 to 72 bytes) and compresses one or two more blocks
// before the digest appears.
// The digest is held in an output register; if the receiver stalls, the
// block waits with the next message's input closed once it has the next
// digest ready. Reset (aresetn low at a clock edge) restores the initial
// chaining value and drops any partial message and any pending digest.
// ----------------------------------------------------------------------------
module md5_message_digest
    import md5_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
    input  wire logic         s_tuser,   // [0] has_byte
    input  wire logic         s_tlast,   // last
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata    // [63:0] digest_low, [127:64] digest_high
);

    // Main sequencer.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,   // taking message bytes
        ST_PAD  = 6'b000010,   // writing padding and length bytes
        ST_LOAD = 6'b000100,   // first memory read of a compression
        ST_COMP = 6'b001000,   // one round per cycle
        ST_FOLD = 6'b010000,   // add the working words into the chain
        ST_DONE = 6'b100000    // hand the digest to the output register
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  byte_pos_reg, byte_pos_next;
    logic [31:0] bit_cnt_reg, bit_cnt_next;
    logic [5:0]  round_reg, round_next;
    logic        pad_mode_reg, pad_mode_next;    // padding is under way
    logic        pad_first_reg, pad_first_next;  // next pad byte is the marker
    logic        len_phase_reg, len_phase_next;  // length block has been reached
    logic        final_reg, final_next;          // this compression ends the message
    logic        m_valid_reg, m_valid_next;
    md5_state_t  chain_reg, chain_next;
    md5_state_t  work_reg, work_next;
    logic [31:0] acc_reg, acc_next;
    logic [127:0] m_data_reg, m_data_next;

    md5_state_t  round_out;

    // Block buffer: 16 words, synchronous read into a read data register.
    logic [31:0] buf_mem [16];
    logic [31:0] rd_data_reg;
    logic [3:0]  rd_addr;
    logic        rd_en;

    logic        put_en;
    logic [7:0]  put_byte;
    logic        in_len;
    logic        mem_we;
    logic        block_full;
    logic        accept;
    logic        out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Once past the marker, position 56 opens the block that carries the
    // length; the marker itself may sit in 56..63 of the block before.
    assign in_len = !pad_first_reg && ((byte_pos_reg == 6'd56) || len_phase_reg);

    always_comb begin
        put_en   = 1'b0;
        put_byte = 8'h00;
        if (state_reg == ST_IDLE) begin
            put_en   = accept && s_tuser;
            put_byte = s_tdata;
        end else if (state_reg == ST_PAD) begin
            put_en = 1'b1;
            if (pad_first_reg) begin
                put_byte = PAD_MARK;
            end else if (in_len && (byte_pos_reg[5:2] == 4'd14)) begin
                put_byte = bit_cnt_reg[{byte_pos_reg[1:0], 3'b000} +: 8];
            end else begin
                put_byte = 8'h00;
            end
        end
    end

    // Bytes are gathered into a word register and written as whole words.
    always_comb begin
        acc_next = acc_reg;
        if (put_en) begin
            acc_next[{byte_pos_reg[1:0], 3'b000} +: 8] = put_byte;
        end
    end

    assign mem_we     = put_en && (byte_pos_reg[1:0] == 2'd3);
    assign block_full = put_en && (byte_pos_reg == 6'd63);

    // The read for round r+1 goes out while round r is computed.
    assign rd_en   = (state_reg == ST_LOAD) || (state_reg == ST_COMP);
    assign rd_addr = (state_reg == ST_LOAD) ? md5_index(6'd0) : md5_index(round_reg + 6'd1);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            buf_mem[byte_pos_reg[5:2]] <= acc_next;
        end
        if (rd_en) begin
            rd_data_reg <= buf_mem[rd_addr];
        end
    end

    md5_round u_round (
        .cur_state  (work_reg),
        .msg_word   (rd_data_reg),
        .round_idx  (round_reg),
        .next_state (round_out)
    );

    always_comb begin
        state_next     = state_reg;
        byte_pos_next  = byte_pos_reg;
        bit_cnt_next   = bit_cnt_reg;
        round_next     = round_reg;
        pad_mode_next  = pad_mode_reg;
        pad_first_next = pad_first_reg;
        len_phase_next = len_phase_reg;
        final_next     = final_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        chain_next     = chain_reg;
        work_next      = work_reg;
        m_data_next    = m_data_reg;

        if (put_en) begin
            byte_pos_next = byte_pos_reg + 6'd1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser) begin
                        bit_cnt_next = bit_cnt_reg + 32'd8;
                    end
                    if (s_tlast) begin
                        pad_mode_next  = 1'b1;
                        pad_first_next = 1'b1;
                    end
                    if (block_full) begin
                        state_next = ST_LOAD;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                pad_first_next = 1'b0;
                len_phase_next = len_phase_reg || in_len;
                if (block_full) begin
                    final_next = in_len;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                work_next  = chain_reg;
                round_next = 6'd0;
                state_next = ST_COMP;
            end
            ST_COMP: begin
                work_next  = round_out;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                chain_next.a = chain_reg.a + work_reg.a;
                chain_next.b = chain_reg.b + work_reg.b;
                chain_next.c = chain_reg.c + work_reg.c;
                chain_next.d = chain_reg.d + work_reg.d;
                if (final_reg) begin
                    state_next = ST_DONE;
                end else if (pad_mode_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_next    = chain_reg;
                    m_valid_next   = 1'b1;
                    chain_next     = '{d: IV_D, c: IV_C, b: IV_B, a: IV_A};
                    bit_cnt_next   = 32'd0;
                    byte_pos_next  = 6'd0;
                    pad_mode_next  = 1'b0;
                    pad_first_next = 1'b0;
                    len_phase_next = 1'b0;
                    final_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            byte_pos_reg  <= 6'd0;
            bit_cnt_reg   <= 32'd0;
            round_reg     <= 6'd0;
            pad_mode_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            len_phase_reg <= 1'b0;
            final_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            chain_reg     <= '{d: IV_D, c: IV_C, b: IV_B, a: IV_A};
        end else begin
            state_reg     <= state_next;
            byte_pos_reg  <= byte_pos_next;
            bit_cnt_reg   <= bit_cnt_next;
            round_reg     <= round_next;
            pad_mode_reg  <= pad_mode_next;
            pad_first_reg <= pad_first_next;
            len_phase_reg <= len_phase_next;
            final_reg     <= final_next;
            m_valid_reg   <= m_valid_next;
            chain_reg     <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg   <= work_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    // A compression only starts on a block boundary.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> (byte_pos_reg == 6'd0))
        else $error("compression started inside a block");

    // The block memory is never written while a compression reads it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !((state_reg == ST_LOAD) || (state_reg == ST_COMP)))
        else $error("block buffer written during compression");

    // The last round hands over to the fold step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_COMP) && (round_reg == 6'd63)) |=> (state_reg == ST_FOLD))
        else $error("round loop did not end after 64 rounds");

    // Delivering a digest presents it and restarts the hash state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DONE) && out_free) |=>
            (m_valid_reg && (chain_reg.a == IV_A) && (bit_cnt_reg == 32'd0)))
        else $error("hash state not restarted after digest");
`endif

endmodule
`default_nettype wire
